/* rtl/hte_pkg.sv */
// Shared constants and types of the table-driven Huffman encoder and packer.
package hte_pkg;

  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;
  localparam int LEN_W    = 6;
  localparam int CODE_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int TOTAL_W  = 32;
  localparam int FILL_W   = 3;
  localparam int PART_W   = 7;
  localparam int ACC_W    = PART_W + CODE_W;
  localparam int ALN_W    = ACC_W + 1;
  localparam int OB_W     = 32;
  localparam int OBL_W    = 3;

  localparam int MAX_CODE_BITS   = 32;
  localparam int DEF_NUM_SYMBOLS = 256;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } hte_op_t;

endpackage

/* rtl/hte_in_if.sv */
// Command channel of the Huffman encoder: table loads, symbols and flushes.
interface hte_in_if;
  import hte_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SYM_W-1:0]  symbol;
  logic [LEN_W-1:0]  code_length;
  logic [CODE_W-1:0] code_bits;

  modport source (output valid, opcode, symbol, code_length, code_bits, input ready);
  modport sink   (input valid, opcode, symbol, code_length, code_bits, output ready);
endinterface

/* rtl/hte_out_if.sv */
// Result channel of the Huffman encoder: packed bytes and the bit count.
interface hte_out_if;
  import hte_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               has_byte;
  logic               last;
  logic [TOTAL_W-1:0] total_bits;

  modport source (output valid, out_byte, has_byte, last, total_bits, input ready);
  modport sink   (input valid, out_byte, has_byte, last, total_bits, output ready);
endinterface

/* rtl/huffman_table_encoder_packer_top.sv */
// Table-driven Huffman encoder with an MSB-first byte packer.
//
// Channels: cmd takes one word per item (opcode, symbol, code_length,
// code_bits); res gives packed bytes with has_byte, last and total_bits.
// A load writes one table entry and gives no result. An encode appends the
// symbol's code and gives one result per completed byte, the final one
// marked last. A flush gives one result with the zero-padded partial byte
// (has_byte low when nothing is pending) and the bit count, then clears.
// An item's results pass through the table read register and then the
// result register.
// Throughput: one item per cycle while each item yields at most one result
// and res.ready is high; an item can yield up to four bytes and holds the
// result register until all are taken, one at a time through the single-byte result port.
// Reset: clears the length valid bits (all codes read as absent), the packer
// and the bit count; the code memory is not cleared and needs no sweep.
// A stalled receiver holds the current result; one more item waits in the
// read register, after which cmd.ready drops.
module huffman_table_encoder_packer_top #(
  parameter int NUM_SYMBOLS = hte_pkg::DEF_NUM_SYMBOLS
) (
  input logic      clk,
  input logic      rst,
  hte_in_if.sink   cmd,
  hte_out_if.source res
);
  import hte_pkg::*;

  localparam int IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LEN_LIM = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

  logic [CODE_W-1:0]  code_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0]   len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] len_vld;

  logic               cmd_fire;
  logic [IDX_W-1:0]   cmd_idx;
  logic               cmd_inrange;
  logic               cmd_load;
  logic [LEN_W-1:0]   load_len;

  logic               s1_full;
  logic [OP_W-1:0]    s1_op;
  logic               s1_hit;
  logic [CODE_W-1:0]  s1_code;
  logic [LEN_W-1:0]   s1_len;
  logic               s1_is_enc;
  logic               s1_is_flush;
  logic               s1_needs_ob;
  logic               s1_fire;

  logic [PART_W-1:0]  partial;
  logic [FILL_W-1:0]  fill;
  logic [TOTAL_W-1:0] bit_total;

  logic [LEN_W-1:0]   enc_len;
  logic [CODE_W:0]    code_mask;
  logic [ACC_W-1:0]   acc;
  logic [LEN_W-1:0]   total;
  logic [OBL_W-1:0]   nbytes;
  logic [ALN_W-1:0]   aligned;
  logic [PART_W:0]    part_mask;
  logic [PART_W-1:0]  partial_enc;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_enc;
  logic [FILL_W:0]    fl_sh;
  logic [BYTE_W-1:0]  fl_byte;

  logic [OB_W-1:0]    ob_bytes;
  logic [OBL_W-1:0]   ob_left;
  logic               ob_has;
  logic [TOTAL_W-1:0] ob_total;
  logic               ob_free;
  logic               res_fire;

  assign cmd_fire    = cmd.valid && cmd.ready;
  assign cmd_idx     = cmd.symbol[IDX_W-1:0];
  assign cmd_inrange = {1'b0, cmd.symbol} < (SYM_W+1)'(NUM_SYMBOLS);
  assign cmd_load    = cmd_fire && (cmd.opcode == OP_LOAD) && cmd_inrange;
  assign load_len    = (cmd.code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : cmd.code_length;

  always_ff @(posedge clk) begin
    if (cmd_load) begin
      code_mem[cmd_idx] <= cmd.code_bits;
      len_mem[cmd_idx]  <= load_len;
    end
    if (cmd_fire) begin
      s1_code <= code_mem[cmd_idx];
      s1_len  <= len_mem[cmd_idx];
      s1_op   <= cmd.opcode;
      s1_hit  <= cmd_inrange && len_vld[cmd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
      s1_full <= 1'b0;
    end else begin
      if (cmd_load) begin
        len_vld[cmd_idx] <= 1'b1;
      end
      if (cmd.ready) begin
        s1_full <= cmd.valid;
      end
    end
  end

  // pack
  always_comb begin
    s1_is_enc   = s1_full && (s1_op == OP_ENCODE);
    s1_is_flush = s1_full && (s1_op == OP_FLUSH);
    enc_len     = (s1_is_enc && s1_hit) ? s1_len : '0;
    code_mask   = ((CODE_W+1)'(1) << enc_len) - (CODE_W+1)'(1);
    acc         = (ACC_W'(partial) << enc_len) | ACC_W'(s1_code & code_mask[CODE_W-1:0]);
    total       = LEN_W'(fill) + enc_len;
    nbytes      = total[LEN_W-1:FILL_W];
    aligned     = {1'b0, acc} << (LEN_W'(ALN_W) - total);
    part_mask   = ((PART_W+1)'(1) << total[FILL_W-1:0]) - (PART_W+1)'(1);
    partial_enc = acc[PART_W-1:0] & part_mask[PART_W-1:0];
    sum         = {1'b0, bit_total} + (TOTAL_W+1)'(enc_len);
    total_enc   = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    fl_sh       = (FILL_W+1)'(BYTE_W) - {1'b0, fill};
    fl_byte     = {1'b0, partial} << fl_sh;
  end

  assign ob_free     = (ob_left == '0) || ((ob_left == OBL_W'(1)) && res.ready);
  assign s1_needs_ob = s1_is_flush || (s1_is_enc && (nbytes != '0));
  assign s1_fire     = s1_full && (!s1_needs_ob || ob_free);
  assign cmd.ready   = !rst && (!s1_full || s1_fire);
  assign res_fire    = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= '0;
      fill      <= '0;
      bit_total <= '0;
    end else if (s1_fire && s1_is_flush) begin
      partial   <= '0;
      fill      <= '0;
      bit_total <= '0;
    end else if (s1_fire && s1_is_enc) begin
      partial   <= partial_enc;
      fill      <= total[FILL_W-1:0];
      bit_total <= total_enc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_left <= '0;
    end else if (s1_fire && s1_needs_ob) begin
      if (s1_is_flush) begin
        ob_bytes <= {fl_byte, (OB_W-BYTE_W)'(0)};
        ob_left  <= OBL_W'(1);
        ob_has   <= (fill != '0);
        ob_total <= bit_total;
      end else begin
        ob_bytes <= aligned[ALN_W-1 -: OB_W];
        ob_left  <= nbytes;
        ob_has   <= 1'b1;
        ob_total <= total_enc;
      end
    end else if (res_fire) begin
      ob_bytes <= ob_bytes << BYTE_W;
      ob_left  <= ob_left - OBL_W'(1);
    end
  end

  assign res.valid      = (ob_left != '0);
  assign res.out_byte   = ob_bytes[OB_W-1 -: BYTE_W];
  assign res.has_byte   = ob_has;
  assign res.last       = (ob_left == OBL_W'(1));
  assign res.total_bits = ob_total;

endmodule

/* rtl/hte_checker.sv */
// Port-level checks of the Huffman encoder result channel, bound to the top level.
module hte_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [hte_pkg::BYTE_W-1:0] res_out_byte,
  input logic                       res_has_byte,
  input logic                       res_last
);
  import hte_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_out_byte) && $stable(res_last))
    else $error("result dropped or changed while stalled");

  a_empty_flush: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_has_byte |-> res_last && (res_out_byte == '0))
    else $error("empty flush result not last or not zero");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> res_valid && res_has_byte)
    else $error("byte burst broken before its last word");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind huffman_table_encoder_packer_top hte_checker u_hte_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_out_byte (res.out_byte),
  .res_has_byte (res.has_byte),
  .res_last     (res.last)
);

/* dv/tb_huffman_table_encoder_packer_top.sv */
// Testbench for the Huffman table encoder and byte packer: directed and random words, self-checked.
module tb_huffman_table_encoder_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hte_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int NUM_SYM        = DEF_NUM_SYMBOLS;
  localparam int HOLD_CYCLES    = 48;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 250;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               has_byte;
    logic               last;
    logic [TOTAL_W-1:0] total_bits;
  } packed_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hte_in_if  cmd_if ();
  hte_out_if res_if ();

  huffman_table_encoder_packer_top u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  packed_out_t        expected_out [$];
  logic [CODE_W-1:0]  code_mem [NUM_SYM];
  logic [LEN_W-1:0]   len_mem [NUM_SYM];
  bit                 written [NUM_SYM];
  logic [SYM_W-1:0]   loaded_syms [$];
  logic [PART_W-1:0]  pend_bits;
  logic [FILL_W-1:0]  pend_cnt;
  logic [TOTAL_W-1:0] bit_count;

  bit idle_en;
  bit hold_off_req;
  int errors;
  int n_words;
  int n_results;
  int n_flushes;
  int quiet_cycles;

  function automatic void model_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                     logic [LEN_W-1:0] len, logic [CODE_W-1:0] bits);
    packed_out_t r;
    logic [63:0] acc;
    logic [32:0] sum;
    int          n_bits;
    int          fill;
    int          n_bytes;
    case (op)
      OP_LOAD: begin
        code_mem[sym] = bits;
        len_mem[sym]  = (len > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS) : len;
        if (!written[sym]) begin
          written[sym] = 1'b1;
          loaded_syms = {loaded_syms, sym};
        end
      end
      OP_ENCODE: begin
        n_bits = int'(len_mem[sym]);
        if (n_bits != 0) begin
          acc = ({57'd0, pend_bits} << n_bits) |
                ({32'd0, code_mem[sym]} & ((64'd1 << n_bits) - 64'd1));
          fill = int'(pend_cnt) + n_bits;
          sum = {1'b0, bit_count} + 33'(n_bits);
          bit_count = sum[32] ? '1 : sum[31:0];
          n_bytes = fill / BYTE_W;
          for (int k = 0; k < n_bytes; k++) begin
            fill = fill - BYTE_W;
            r.out_byte   = BYTE_W'(acc >> fill);
            r.has_byte   = 1'b1;
            r.last       = (k == n_bytes - 1);
            r.total_bits = bit_count;
            expected_out = {expected_out, r};
          end
          pend_bits = PART_W'(acc & ((64'd1 << fill) - 64'd1));
          pend_cnt  = FILL_W'(fill);
        end
      end
      OP_FLUSH: begin
        r.has_byte   = (pend_cnt != 0);
        r.out_byte   = r.has_byte ? BYTE_W'({1'b0, pend_bits} << (BYTE_W - int'(pend_cnt))) : '0;
        r.last       = 1'b1;
        r.total_bits = bit_count;
        expected_out = {expected_out, r};
        pend_bits = '0;
        pend_cnt  = '0;
        bit_count = '0;
        n_flushes++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 15) return LEN_W'($urandom_range(33, 63));
    if (pick < 35) return LEN_W'($urandom_range(17, 32));
    return LEN_W'($urandom_range(1, 16));
  endfunction

  task automatic send_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                           logic [LEN_W-1:0] len, logic [CODE_W-1:0] bits);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.opcode      <= op;
    cmd_if.symbol      <= sym;
    cmd_if.code_length <= len;
    cmd_if.code_bits   <= bits;
    do @(posedge clk); while (!cmd_if.ready);
    n_words++;
    model_word(op, sym, len, bits);
  endtask

  task automatic test_reset_state();
    send_word(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    send_word(OP_NONE, 8'hFF, 6'd63, 32'hFFFF_FFFF);
    send_word(OP_FLUSH, 8'hFF, 6'd63, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed_codes();
    send_word(OP_LOAD, 8'h00, 6'd0, 32'hFFFF_FFFF);
    send_word(OP_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
    send_word(OP_LOAD, 8'h01, 6'd1, 32'h0000_0001);
    send_word(OP_LOAD, 8'h02, 6'd7, 32'h0000_0055);
    send_word(OP_LOAD, 8'h03, 6'd63, 32'hA5A5_A5A5);
    send_word(OP_LOAD, 8'h04, 6'd33, 32'h1234_5678);
    send_word(OP_LOAD, 8'h05, 6'd3, 32'hFFFF_FFFA);
    send_word(OP_LOAD, 8'h80, 6'd8, 32'h0000_0000);
    send_word(OP_ENCODE, 8'h00, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'h01, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'hFF, 6'd63, 32'hFFFF_FFFF);
    send_word(OP_ENCODE, 8'h02, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'h03, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'h05, 6'd0, 32'h0);
    send_word(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    send_word(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'h04, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'h80, 6'd0, 32'h0);
    send_word(OP_ENCODE, 8'h01, 6'd0, 32'h0);
    send_word(OP_NONE, 8'h01, 6'd1, 32'h1);
    send_word(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  task automatic test_random_stream(int count);
    int pick;
    logic [SYM_W-1:0] sym;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(OP_LOAD, SYM_W'($urandom()), random_length(), $urandom());
      end else if (pick < 89) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_word(OP_ENCODE, sym, LEN_W'($urandom()), $urandom());
      end else if (pick < 97) begin
        send_word(OP_FLUSH, SYM_W'($urandom()), LEN_W'($urandom()), $urandom());
      end else begin
        send_word(OP_NONE, SYM_W'($urandom()), LEN_W'($urandom()), $urandom());
      end
    end
  endtask

  task automatic test_result_hold_off();
    send_word(OP_LOAD, 8'hFF, 6'd32, $urandom());
    hold_off_req = 1'b1;
    for (int i = 0; i < 16; i++) send_word(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
    send_word(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  task automatic test_full_rate();
    logic [SYM_W-1:0] short_syms [4];
    idle_en = 1'b0;
    for (int i = 0; i < 4; i++) begin
      short_syms[i] = SYM_W'($urandom());
      send_word(OP_LOAD, short_syms[i], LEN_W'($urandom_range(1, 8)), $urandom());
    end
    for (int i = 0; i < 30; i++) begin
      send_word(OP_ENCODE, short_syms[$urandom_range(0, 3)], 6'd0, 32'h0);
    end
    send_word(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  always @(posedge clk) begin : check_results
    packed_out_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      n_results++;
      if (expected_out.size() == 0) begin
        $error("unexpected result: out_byte %0h has_byte %0b last %0b total_bits %0d",
               res_if.out_byte, res_if.has_byte, res_if.last, res_if.total_bits);
        errors++;
      end else begin
        want = expected_out[0];
        expected_out.delete(0);
        if (res_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, res_if.out_byte);
          errors++;
        end
        if (res_if.has_byte !== want.has_byte) begin
          $error("has_byte: expected %0b, got %0b", want.has_byte, res_if.has_byte);
          errors++;
        end
        if (res_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_if.last);
          errors++;
        end
        if (res_if.total_bits !== want.total_bits) begin
          $error("total_bits: expected %0d, got %0d", want.total_bits, res_if.total_bits);
          errors++;
        end
      end
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // hold the result channel off so the block fills and stalls its input
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        res_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no word moved for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cmd_if.valid       <= 1'b0;
    cmd_if.opcode      <= OP_LOAD;
    cmd_if.symbol      <= '0;
    cmd_if.code_length <= '0;
    cmd_if.code_bits   <= '0;
    pend_bits    = '0;
    pend_cnt     = '0;
    bit_count    = '0;
    idle_en      = 1'b1;
    hold_off_req = 1'b0;
    n_words      = 0;
    n_flushes    = 0;
    foreach (len_mem[i]) begin
      len_mem[i]  = '0;
      code_mem[i] = '0;
      written[i]  = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_codes();
    test_random_stream(RANDOM_WORDS);
    test_result_hold_off();
    test_full_rate();

    cmd_if.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d command words, %0d result bytes and %0d flushes,",
             n_words, n_results, n_flushes);
    $display("with overlong and zero lengths, random stalls and a long result hold-off.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
